@@ hw/rtl/clx_pkg.sv @@
// clx_pkg: shared types, token kind codes, byte classes and keyword tables
// for the C subset lexer. No dependencies.
package clx_pkg;

  // Byte classes produced by the front end.
  typedef enum logic [2:0] {
    CLS_LETTER,
    CLS_DIGIT,
    CLS_EQ,
    CLS_BANG,
    CLS_LT,
    CLS_GT,
    CLS_SPACE,
    CLS_OTHER
  } cls_t;

  typedef logic [4:0] kind_t;

  localparam kind_t KIND_IDENT   = 5'd0;
  localparam kind_t KIND_LITERAL = 5'd1;
  localparam kind_t KIND_INT     = 5'd2;  // first keyword; if/else/while/return follow
  localparam kind_t KIND_PLUS    = 5'd7;
  localparam kind_t KIND_MINUS   = 5'd8;
  localparam kind_t KIND_STAR    = 5'd9;
  localparam kind_t KIND_SLASH   = 5'd10;
  localparam kind_t KIND_PERCENT = 5'd11;
  localparam kind_t KIND_ASSIGN  = 5'd12;
  localparam kind_t KIND_EQ      = 5'd13;
  localparam kind_t KIND_NE      = 5'd14;
  localparam kind_t KIND_LT      = 5'd15;
  localparam kind_t KIND_LE      = 5'd16;
  localparam kind_t KIND_GT      = 5'd17;
  localparam kind_t KIND_GE      = 5'd18;
  localparam kind_t KIND_LPAREN  = 5'd19;
  localparam kind_t KIND_RPAREN  = 5'd20;
  localparam kind_t KIND_LBRACE  = 5'd21;
  localparam kind_t KIND_RBRACE  = 5'd22;
  localparam kind_t KIND_SEMI    = 5'd23;
  localparam kind_t KIND_COMMA   = 5'd24;
  localparam kind_t KIND_ERROR   = 5'd25;
  localparam kind_t KIND_EOF     = 5'd26;

  // Keywords: int, if, else, while, return.
  localparam int KW_NUM    = 5;
  localparam int KW_MAXLEN = 6;
  localparam int KW_IW     = $clog2(KW_MAXLEN);

  localparam int unsigned KW_LEN [KW_NUM] = '{3, 2, 4, 5, 6};

  localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAXLEN] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},  // int
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},  // else
    '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},  // while
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E}   // return
  };

  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    priority if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") r = CLS_LETTER;
    else if (c >= "0" && c <= "9")                r = CLS_DIGIT;
    else if (c == "=")                            r = CLS_EQ;
    else if (c == "!")                            r = CLS_BANG;
    else if (c == "<")                            r = CLS_LT;
    else if (c == ">")                            r = CLS_GT;
    else if (c == " " || c == 8'h09 || c == 8'h0A) r = CLS_SPACE;
    else                                          r = CLS_OTHER;
    return r;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t r;
    unique case (c)
      "+":     r = KIND_PLUS;
      "-":     r = KIND_MINUS;
      "*":     r = KIND_STAR;
      "/":     r = KIND_SLASH;
      "%":     r = KIND_PERCENT;
      "(":     r = KIND_LPAREN;
      ")":     r = KIND_RPAREN;
      "{":     r = KIND_LBRACE;
      "}":     r = KIND_RBRACE;
      ";":     r = KIND_SEMI;
      ",":     r = KIND_COMMA;
      default: r = KIND_ERROR;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/clx_fifo.sv @@
// clx_fifo: small register queue, up to two writes and one read per cycle.
// Standalone; no package dependency.
module clx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       wr_cnt,     // 0, 1 or 2 entries written this cycle
  input  logic [WIDTH-1:0] wr_data0,
  input  logic [WIDTH-1:0] wr_data1,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [PW-1:0]    wr_ptr1;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr1    = ptr_inc(wr_ptr_r);
    wr_ptr_nxt = wr_ptr_r;
    if (wr_cnt == 2'd1) wr_ptr_nxt = wr_ptr1;
    else if (wr_cnt == 2'd2) wr_ptr_nxt = ptr_inc(wr_ptr1);
    rd_ptr_nxt = rd_en ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(wr_cnt) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wr_ptr_r] <= wr_data0;
    if (wr_cnt == 2'd2) mem_r[wr_ptr1] <= wr_data1;
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign count   = count_r;

endmodule

@@ hw/rtl/clx_front.sv @@
// clx_front: byte classifier and text position counter.
// Depends on clx_pkg.
module clx_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [7:0]               ch,
  input  logic                     text_end,
  output clx_pkg::cls_t            item_cls,
  output clx_pkg::kind_t           item_skind,
  output logic [POSITION_BITS-1:0] item_pos
);
  import clx_pkg::*;

  logic [POSITION_BITS-1:0] text_pos_r, text_pos_nxt;

  always_comb begin
    text_pos_nxt = text_pos_r;
    if (accept) begin
      if (text_end) text_pos_nxt = '0;
      else if (text_pos_r != '1) text_pos_nxt = text_pos_r + 1'b1;  // saturate
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) text_pos_r <= '0;
    else        text_pos_r <= text_pos_nxt;
  end

  assign item_cls   = classify(ch);
  assign item_skind = single_kind(ch);
  assign item_pos   = text_pos_r;

endmodule

@@ hw/rtl/clx_engine.sv @@
// clx_engine: token scanner state machine; turns classified bytes into up to
// two token records per byte. Depends on clx_pkg.
module clx_engine #(
  parameter int POSITION_BITS = 16,
  localparam int RW = 5 + 3 * POSITION_BITS + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  input  logic                     out_room,   // two free result slots
  input  clx_pkg::cls_t            item_cls,
  input  clx_pkg::kind_t           item_skind,
  input  logic [7:0]               item_ch,
  input  logic                     item_end,
  input  logic [POSITION_BITS-1:0] item_pos,
  output logic                     item_pop,
  output logic [1:0]               wr_cnt,
  output logic [RW-1:0]            rec0,
  output logic [RW-1:0]            rec1
);
  import clx_pkg::*;

  localparam int PB = POSITION_BITS;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_EQ, MODE_BANG, MODE_LT, MODE_GT
  } mode_t;

  mode_t             mode_r, mode_nxt;
  logic [PB-1:0]     pend_start_r, pend_start_nxt;
  logic [PB-1:0]     pend_len_r, pend_len_nxt;
  logic [KW_NUM-1:0] hits_r, hits_nxt;
  logic [PB-1:0]     tokens_r, tokens_nxt;

  logic              fire;
  logic              flush_v;
  kind_t             flush_kind, two_kind;
  logic              cont, two;
  logic [KW_NUM-1:0] fresh_hits, cont_hits;
  logic              a_v, b_v;
  kind_t             a_kind, b_kind;
  logic [PB-1:0]     a_start, a_len, b_start, b_len;
  kind_t             r0_kind;
  logic [PB-1:0]     r0_start, r0_len, idx0, idx1;

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    fire = item_valid && out_room;

    // Kind of the pending token if it ends here.
    flush_v    = (mode_r != MODE_IDLE);
    flush_kind = KIND_ERROR;
    unique case (mode_r)
      MODE_IDENT: begin
        flush_kind = KIND_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
          if (hits_r[k] && pend_len_r == PB'(KW_LEN[k])) flush_kind = 5'(KIND_INT + k);
        end
      end
      MODE_NUMBER: flush_kind = KIND_LITERAL;
      MODE_EQ:     flush_kind = KIND_ASSIGN;
      MODE_BANG:   flush_kind = KIND_ERROR;
      MODE_LT:     flush_kind = KIND_LT;
      MODE_GT:     flush_kind = KIND_GT;
      default:     flush_kind = KIND_ERROR;
    endcase

    unique case (mode_r)
      MODE_EQ:   two_kind = KIND_EQ;
      MODE_BANG: two_kind = KIND_NE;
      MODE_LT:   two_kind = KIND_LE;
      default:   two_kind = KIND_GE;
    endcase

    for (int k = 0; k < KW_NUM; k++) begin
      fresh_hits[k] = (item_cls == CLS_LETTER) && (KW_TEXT[k][0] == item_ch);
      cont_hits[k]  = hits_r[k] &&
                      ((pend_len_r < PB'(KW_LEN[k])) ?
                       (KW_TEXT[k][pend_len_r[KW_IW-1:0]] == item_ch) : 1'b0);
    end

    cont = (mode_r == MODE_IDENT && (item_cls == CLS_LETTER || item_cls == CLS_DIGIT)) ||
           (mode_r == MODE_NUMBER && item_cls == CLS_DIGIT);
    two  = (mode_r == MODE_EQ || mode_r == MODE_BANG || mode_r == MODE_LT ||
            mode_r == MODE_GT) && item_cls == CLS_EQ;

    mode_nxt       = mode_r;
    pend_start_nxt = pend_start_r;
    pend_len_nxt   = pend_len_r;
    hits_nxt       = hits_r;
    a_v = 1'b0; a_kind = flush_kind; a_start = pend_start_r; a_len = pend_len_r;
    b_v = 1'b0; b_kind = item_skind; b_start = item_pos;     b_len = PB'(1);

    if (item_end) begin
      // flush, then EOF, then back to reset state
      a_v            = flush_v;
      b_v            = 1'b1;
      b_kind         = KIND_EOF;
      b_len          = '0;
      mode_nxt       = MODE_IDLE;
      pend_start_nxt = '0;
      pend_len_nxt   = '0;
      hits_nxt       = '0;
    end else if (cont) begin
      if (mode_r == MODE_IDENT) hits_nxt = cont_hits;
      pend_len_nxt = sat_inc(pend_len_r);
    end else if (two) begin
      a_v          = 1'b1;
      a_kind       = two_kind;
      a_len        = PB'(2);
      mode_nxt     = MODE_IDLE;
      pend_len_nxt = '0;
    end else begin
      a_v            = flush_v;
      pend_start_nxt = item_pos;
      pend_len_nxt   = PB'(1);
      hits_nxt       = fresh_hits;
      unique case (item_cls)
        CLS_LETTER: mode_nxt = MODE_IDENT;
        CLS_DIGIT:  mode_nxt = MODE_NUMBER;
        CLS_EQ:     mode_nxt = MODE_EQ;
        CLS_BANG:   mode_nxt = MODE_BANG;
        CLS_LT:     mode_nxt = MODE_LT;
        CLS_GT:     mode_nxt = MODE_GT;
        CLS_SPACE: begin
          mode_nxt     = MODE_IDLE;
          pend_len_nxt = '0;
        end
        default: begin
          mode_nxt     = MODE_IDLE;
          pend_len_nxt = '0;
          b_v          = 1'b1;
        end
      endcase
    end

    // Pack records: first emitted token goes to slot 0.
    idx0     = tokens_r;
    idx1     = sat_inc(tokens_r);
    r0_kind  = a_v ? a_kind  : b_kind;
    r0_start = a_v ? a_start : b_start;
    r0_len   = a_v ? a_len   : b_len;
    rec0     = {r0_kind, r0_start, r0_len, idx0, !(a_v && b_v)};
    rec1     = {b_kind, b_start, b_len, idx1, 1'b1};

    item_pop = fire;
    wr_cnt   = fire ? (2'(a_v) + 2'(b_v)) : 2'd0;

    tokens_nxt = tokens_r;
    if (item_end)          tokens_nxt = '0;
    else if (a_v && b_v)   tokens_nxt = sat_inc(idx1);
    else if (a_v || b_v)   tokens_nxt = idx1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      pend_start_r <= '0;
      pend_len_r   <= '0;
      hits_r       <= '0;
      tokens_r     <= '0;
    end else if (fire) begin
      mode_r       <= mode_nxt;
      pend_start_r <= pend_start_nxt;
      pend_len_r   <= pend_len_nxt;
      hits_r       <= hits_nxt;
      tokens_r     <= tokens_nxt;
    end
  end

endmodule

@@ hw/rtl/c_subset_lexer_unit.sv @@
// c_subset_lexer_unit: streaming tokenizer top level.
// Depends on clx_pkg, clx_fifo, clx_front, clx_engine.
//
// Streaming lexer for a small C subset. One text byte (or an end-of-text
// mark) is taken per push transaction; tokens come out as pop transactions
// carrying kind, start position, length, sequence index and a last flag that
// marks the final token caused by a given input byte. A byte that ends a
// pending token and also forms a token of its own produces two tokens; a
// byte that extends a token produces none, and a whitespace byte produces
// none of its own. The block takes one byte per cycle sustained; each byte
// is registered in the front queue and its tokens in the result queue
// before they can be popped. The sustained rate is set by the scanner
// engine, which retires one queued byte per cycle whenever the four-entry
// result queue has two free slots; a consumer that pops every cycle never
// slows the input. There is no clearing pass after reset; full is low from
// the first cycle after reset.
module c_subset_lexer_unit #(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input queue side
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               in_ch,
  input  logic                     in_text_end,
  // result queue side
  output logic                     empty,
  input  logic                     pop,
  output logic [4:0]               out_token_kind,
  output logic [POSITION_BITS-1:0] out_token_start,
  output logic [POSITION_BITS-1:0] out_token_length,
  output logic [POSITION_BITS-1:0] out_token_index,
  output logic                     out_last
);
  import clx_pkg::*;

  localparam int PB        = POSITION_BITS;
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int MID_CW    = $clog2(MID_DEPTH + 1);
  localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);
  // front item: class, single-char kind, byte, end mark, position
  localparam int IW        = 3 + 5 + 8 + 1 + PB;
  // token record: kind, start, length, index, last
  localparam int RW        = 5 + 3 * PB + 1;

  logic              in_accept;
  cls_t              f_cls;
  kind_t             f_skind;
  logic [PB-1:0]     f_pos;
  logic [IW-1:0]     mid_wr, mid_rd;
  logic [MID_CW-1:0] mid_count;

  cls_t              e_cls;
  kind_t             e_skind;
  logic [7:0]        e_ch;
  logic              e_end;
  logic [PB-1:0]     e_pos;
  logic              e_pop;
  logic [1:0]        e_wr_cnt;
  logic [RW-1:0]     e_rec0, e_rec1, out_rd;
  logic [OUT_CW-1:0] out_count;
  logic              out_room;

  assign in_accept = push && !full;
  assign full      = (mid_count == MID_CW'(MID_DEPTH));

  // Front: classify the byte and stamp its position.
  clx_front #(.POSITION_BITS(PB)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .ch         (in_ch),
    .text_end   (in_text_end),
    .item_cls   (f_cls),
    .item_skind (f_skind),
    .item_pos   (f_pos)
  );

  assign mid_wr = {f_cls, f_skind, in_ch, in_text_end, f_pos};

  // Decoupling queue between front and scanner.
  clx_fifo #(.WIDTH(IW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   ({1'b0, in_accept}),
    .wr_data0 (mid_wr),
    .wr_data1 ('0),
    .rd_en    (e_pop),
    .rd_data  (mid_rd),
    .count    (mid_count)
  );

  assign e_cls   = cls_t'(mid_rd[IW-1 -: 3]);
  assign e_skind = mid_rd[IW-4 -: 5];
  assign e_ch    = mid_rd[IW-9 -: 8];
  assign e_end   = mid_rd[PB];
  assign e_pos   = mid_rd[PB-1:0];

  // Scanner only advances when both tokens of a worst-case byte fit.
  assign out_room = (out_count <= OUT_CW'(OUT_DEPTH - 2));

  clx_engine #(.POSITION_BITS(PB)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (mid_count != '0),
    .out_room   (out_room),
    .item_cls   (e_cls),
    .item_skind (e_skind),
    .item_ch    (e_ch),
    .item_end   (e_end),
    .item_pos   (e_pos),
    .item_pop   (e_pop),
    .wr_cnt     (e_wr_cnt),
    .rec0       (e_rec0),
    .rec1       (e_rec1)
  );

  // Result queue: up to two tokens in, one out per cycle.
  clx_fifo #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_cnt   (e_wr_cnt),
    .wr_data0 (e_rec0),
    .wr_data1 (e_rec1),
    .rd_en    (pop && !empty),
    .rd_data  (out_rd),
    .count    (out_count)
  );

  assign empty            = (out_count == '0);
  assign out_token_kind   = out_rd[RW-1 -: 5];
  assign out_token_start  = out_rd[3*PB -: PB];
  assign out_token_length = out_rd[2*PB -: PB];
  assign out_token_index  = out_rd[PB -: PB];
  assign out_last         = out_rd[0];

endmodule

@@ hw/rtl/clx_checker.sv @@
// clx_checker: port-level assertions for c_subset_lexer_unit, with bind.
// Depends on clx_pkg.
module clx_checker #(
  parameter int POSITION_BITS = 16
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     empty,
  input logic                     pop,
  input logic [4:0]               out_token_kind,
  input logic [POSITION_BITS-1:0] out_token_start,
  input logic [POSITION_BITS-1:0] out_token_length,
  input logic [POSITION_BITS-1:0] out_token_index,
  input logic                     out_last
);
  import clx_pkg::*;

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_token_kind) && $stable(out_token_index) &&
                       $stable(out_token_start) && $stable(out_token_length))
    else $error("stalled result changed");

  // Tokens of one byte are queued together, so a non-last one is followed at once.
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !empty && !out_last |=> !empty)
    else $error("second token of a byte missing");

  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_token_kind == KIND_EOF |-> out_last && out_token_length == '0)
    else $error("EOF token malformed");

  a_two: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && (out_token_kind == KIND_EQ || out_token_kind == KIND_NE ||
               out_token_kind == KIND_LE || out_token_kind == KIND_GE)
    |-> out_token_length == POSITION_BITS'(2))
    else $error("two-character operator with wrong length");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_token_kind <= KIND_EOF)
    else $error("token kind out of range");

endmodule

bind c_subset_lexer_unit clx_checker #(.POSITION_BITS(POSITION_BITS)) u_clx_checker (.*);
